/* rtl/status_led_blink_code_driver_core_macros.svh */
// Assertion macros for the status LED blink-code driver RTL.
`ifndef STATUS_LED_BLINK_CODE_DRIVER_CORE_MACROS_SVH
`define STATUS_LED_BLINK_CODE_DRIVER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// The condition must hold at every clock edge outside reset.
`define SLED_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sled assertion failed: invariant");
// When the antecedent holds, the consequent must hold in the same cycle.
`define SLED_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sled assertion failed: implication");
// When the antecedent holds, the consequent must hold in the next cycle.
`define SLED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sled assertion failed: next cycle");
`else
`define SLED_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define SLED_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/sled_pkg.sv */
// Types and constants shared by the status LED blink-code driver modules.
package sled_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CodeW  = 4;
  localparam int unsigned IntvW  = 16;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  // Register index codes.
  localparam logic [1:0] RegSafeHalf  = 2'd0;
  localparam logic [1:0] RegArmedHalf = 2'd1;
  localparam logic [1:0] RegCodePulse = 2'd2;
  localparam logic [1:0] RegCodeGap   = 2'd3;

  localparam logic [IntvW-1:0] SafeHalfReset  = 16'd500;
  localparam logic [IntvW-1:0] ArmedHalfReset = 16'd100;
  localparam logic [IntvW-1:0] CodePulseReset = 16'd100;
  localparam logic [IntvW-1:0] CodeGapReset   = 16'd1000;

  typedef struct packed {
    logic [IntvW-1:0] safe_half_period_ms;
    logic [IntvW-1:0] armed_half_period_ms;
    logic [IntvW-1:0] code_pulse_ms;
    logic [IntvW-1:0] code_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic [CodeW-1:0] error_code;
    logic             link_ok;
    logic             armed;
  } item_t;

  typedef struct packed {
    logic             pin_level;
    logic             toggle_flag;
    logic [TimeW-1:0] last_change_ms;
    logic [CodeW-1:0] pulses_done;
    logic             in_gap;
    logic [CodeW-1:0] previous_code;
  } blink_state_t;

endpackage

/* rtl/sled_step.sv */
// Next-state logic of the blink-code driver for one status update item.
module sled_step (
  input  sled_pkg::cfg_t         cfg,
  input  sled_pkg::item_t        item,
  input  sled_pkg::blink_state_t cur,
  output sled_pkg::blink_state_t nxt
);

  sled_pkg::blink_state_t         st;
  logic [sled_pkg::IntvW-1:0]     interval;
  logic [sled_pkg::TimeW-1:0]     diff;
  logic                           due;
  logic [sled_pkg::CodeW-1:0]     pulses_inc;

  always_comb begin
    st = cur;
    // A new nonzero code restarts the sequence before the timing check.
    if (item.error_code != '0 && item.error_code != cur.previous_code) begin
      st.in_gap         = 1'b0;
      st.pulses_done    = '0;
      st.last_change_ms = item.now_ms;
      st.toggle_flag    = 1'b0;
      st.pin_level      = 1'b0;
      st.previous_code  = item.error_code;
    end

    if (item.error_code != '0) begin
      interval = st.in_gap ? cfg.code_gap_ms : cfg.code_pulse_ms;
    end else if (item.armed) begin
      interval = cfg.armed_half_period_ms;
    end else begin
      interval = cfg.safe_half_period_ms;
    end

    diff       = item.now_ms - st.last_change_ms;
    due        = diff >= {{(sled_pkg::TimeW - sled_pkg::IntvW){1'b0}}, interval};
    pulses_inc = st.pulses_done + 1'b1;

    nxt = st;
    if (item.error_code != '0) begin
      if (!st.in_gap) begin
        if (due) begin
          nxt.last_change_ms = item.now_ms;
          if (st.toggle_flag) begin
            nxt.pin_level   = 1'b0;
            nxt.toggle_flag = 1'b0;
            if (pulses_inc >= item.error_code) begin
              nxt.in_gap      = 1'b1;
              nxt.pulses_done = '0;
            end else begin
              nxt.pulses_done = pulses_inc;
            end
          end else begin
            nxt.pin_level   = 1'b1;
            nxt.toggle_flag = 1'b1;
          end
        end
      end else begin
        nxt.pin_level = 1'b0;
        if (due) begin
          nxt.in_gap         = 1'b0;
          nxt.last_change_ms = item.now_ms;
        end
      end
    end else if (!item.link_ok) begin
      // Solid on; the blink phase and timestamp are left alone.
      nxt.pin_level = 1'b1;
    end else if (due) begin
      nxt.last_change_ms = item.now_ms;
      nxt.toggle_flag    = ~st.toggle_flag;
      nxt.pin_level      = ~st.toggle_flag;
    end
  end

endmodule

/* rtl/status_led_blink_code_driver_core.sv */
// Top level of the status LED blink-code driver: handshakes, registers and state.
//
// Usage: each input item (in_now_ms, in_error_code, in_link_ok, in_armed) is a
// status update carrying the current millisecond timestamp. For every accepted
// item the block returns exactly one result item, out_led_on, the LED pin level
// after that update. An item is taken at a rising edge where in_valid is high
// and in_stall is low; a result is taken where out_valid is high and out_stall
// is low.
// An accepted item sits in the input register until the output register is free;
// the combinational state update (one 32-bit wrapping subtract and compare) then
// loads the result register. Throughput is one item per cycle while the receiver
// does not stall. When the receiver stalls, the result holds in the output
// register and one further item may wait in the input register; only then is
// in_stall raised. Reset (rst_n low at a clock edge) empties both registers,
// turns the LED off, clears the blink state and loads the default intervals
// (500, 100, 100 and 1000 ms). The four 16-bit intervals are written over the
// APB-style cfg_ port at byte addresses 0, 4, 8 and 12; the user must write them
// only while the block is idle, which the block itself does not enforce.
`include "status_led_blink_code_driver_core_macros.svh"

module status_led_blink_code_driver_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sled_pkg::TimeW-1:0]    in_now_ms,
  input  logic [sled_pkg::CodeW-1:0]    in_error_code,
  input  logic                          in_link_ok,
  input  logic                          in_armed,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_led_on,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [sled_pkg::AddrW-1:0]    cfg_paddr,
  input  logic [sled_pkg::DataW-1:0]    cfg_pwdata,
  output logic [sled_pkg::DataW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  sled_pkg::cfg_t         cfg_r;
  sled_pkg::item_t        item_r;
  logic                   item_valid_r;
  sled_pkg::blink_state_t state_r;
  sled_pkg::blink_state_t state_nxt;
  logic                   out_valid_r;
  logic                   out_led_r;
  logic                   step_go;
  logic                   in_take;
  logic                   cfg_wr;
  logic [1:0]             cfg_idx;
  logic [sled_pkg::IntvW-1:0] cfg_rd;

  assign step_go  = item_valid_r && (!out_valid_r || !out_stall);
  assign in_take  = in_valid && !in_stall;
  assign in_stall = item_valid_r && !step_go;

  assign out_valid  = out_valid_r;
  assign out_led_on = out_led_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[3:2];

  always_comb begin
    case (cfg_idx)
      sled_pkg::RegSafeHalf:  cfg_rd = cfg_r.safe_half_period_ms;
      sled_pkg::RegArmedHalf: cfg_rd = cfg_r.armed_half_period_ms;
      sled_pkg::RegCodePulse: cfg_rd = cfg_r.code_pulse_ms;
      sled_pkg::RegCodeGap:   cfg_rd = cfg_r.code_gap_ms;
      default:                cfg_rd = '0;
    endcase
  end
  assign cfg_prdata = {{(sled_pkg::DataW - sled_pkg::IntvW){1'b0}}, cfg_rd};

  sled_step u_step (
    .cfg  (cfg_r),
    .item (item_r),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.safe_half_period_ms  <= sled_pkg::SafeHalfReset;
      cfg_r.armed_half_period_ms <= sled_pkg::ArmedHalfReset;
      cfg_r.code_pulse_ms        <= sled_pkg::CodePulseReset;
      cfg_r.code_gap_ms          <= sled_pkg::CodeGapReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        sled_pkg::RegSafeHalf:  cfg_r.safe_half_period_ms  <= cfg_pwdata[15:0];
        sled_pkg::RegArmedHalf: cfg_r.armed_half_period_ms <= cfg_pwdata[15:0];
        sled_pkg::RegCodePulse: cfg_r.code_pulse_ms        <= cfg_pwdata[15:0];
        sled_pkg::RegCodeGap:   cfg_r.code_gap_ms          <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      out_led_r    <= 1'b0;
      state_r      <= '0;
    end else begin
      if (in_take) begin
        item_valid_r <= 1'b1;
      end else if (step_go) begin
        item_valid_r <= 1'b0;
      end
      if (step_go) begin
        out_valid_r <= 1'b1;
        out_led_r   <= state_nxt.pin_level;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.now_ms     <= in_now_ms;
      item_r.error_code <= in_error_code;
      item_r.link_ok    <= in_link_ok;
      item_r.armed      <= in_armed;
    end
  end

  `SLED_ASSERT_ALWAYS(a_led_matches_state, clk, rst_n, out_led_r == state_r.pin_level)
  `SLED_ASSERT_IMP(a_gap_clears_count, clk, rst_n, state_r.in_gap, state_r.pulses_done == '0)
  `SLED_ASSERT_IMP(a_count_below_code, clk, rst_n, state_r.pulses_done != '0,
                   state_r.pulses_done < state_r.previous_code)
  `SLED_ASSERT_NEXT(a_step_gives_result, clk, rst_n, step_go, out_valid_r)
  `SLED_ASSERT_NEXT(a_take_fills_input, clk, rst_n, in_take, item_valid_r)

endmodule

/* test/status_led_blink_code_driver_core_checker.sv */
// Scoreboard for the status LED driver: predicts each pin level and checks every result item.
`timescale 1ns / 1ps

module status_led_blink_code_driver_core_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [sled_pkg::TimeW-1:0] in_now_ms,
  input  logic [sled_pkg::CodeW-1:0] in_error_code,
  input  logic                       in_link_ok,
  input  logic                       in_armed,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       out_led_on,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [sled_pkg::AddrW-1:0] cfg_paddr,
  input  logic [sled_pkg::DataW-1:0] cfg_pwdata,
  output int                         mismatches,
  output int                         levels_pending
);

  sled_pkg::cfg_t         intervals;
  sled_pkg::blink_state_t led_st;
  logic                   led_due[$];

  function automatic bit span_passed(input logic [sled_pkg::TimeW-1:0] now,
                                     input logic [sled_pkg::IntvW-1:0] span);
    logic [sled_pkg::TimeW-1:0] diff;
    diff = now - led_st.last_change_ms;
    return diff >= {{(sled_pkg::TimeW-sled_pkg::IntvW){1'b0}}, span};
  endfunction

  function automatic void toggle_after(input logic [sled_pkg::TimeW-1:0] now,
                                       input logic [sled_pkg::IntvW-1:0] span);
    if (span_passed(now, span)) begin
      led_st.last_change_ms = now;
      led_st.toggle_flag    = ~led_st.toggle_flag;
      led_st.pin_level      = led_st.toggle_flag;
    end
  endfunction

  function automatic void blink_error(input logic [sled_pkg::TimeW-1:0] now,
                                      input logic [sled_pkg::CodeW-1:0] code);
    // A new code restarts the pulse train from the off level.
    if (code != led_st.previous_code) begin
      led_st.in_gap         = 1'b0;
      led_st.pulses_done    = '0;
      led_st.last_change_ms = now;
      led_st.toggle_flag    = 1'b0;
      led_st.pin_level      = 1'b0;
      led_st.previous_code  = code;
    end
    if (!led_st.in_gap) begin
      if (span_passed(now, intervals.code_pulse_ms)) begin
        led_st.last_change_ms = now;
        if (led_st.toggle_flag) begin
          led_st.pin_level   = 1'b0;
          led_st.toggle_flag = 1'b0;
          led_st.pulses_done = led_st.pulses_done + 1'b1;
          if (led_st.pulses_done >= code) begin
            led_st.in_gap      = 1'b1;
            led_st.pulses_done = '0;
          end
        end else begin
          led_st.pin_level   = 1'b1;
          led_st.toggle_flag = 1'b1;
        end
      end
    end else begin
      led_st.pin_level = 1'b0;
      if (span_passed(now, intervals.code_gap_ms)) begin
        led_st.in_gap         = 1'b0;
        led_st.last_change_ms = now;
      end
    end
  endfunction

  function automatic logic next_led_level(input logic [sled_pkg::TimeW-1:0] now,
                                          input logic [sled_pkg::CodeW-1:0] code,
                                          input logic link, input logic arm);
    if (code != '0) blink_error(now, code);
    else if (!link) led_st.pin_level = 1'b1;
    else if (arm) toggle_after(now, intervals.armed_half_period_ms);
    else toggle_after(now, intervals.safe_half_period_ms);
    return led_st.pin_level;
  endfunction

  always @(posedge clk) begin : watch
    logic want;
    if (!rst_n) begin
      intervals.safe_half_period_ms  = sled_pkg::SafeHalfReset;
      intervals.armed_half_period_ms = sled_pkg::ArmedHalfReset;
      intervals.code_pulse_ms        = sled_pkg::CodePulseReset;
      intervals.code_gap_ms          = sled_pkg::CodeGapReset;
      led_st = '0;
      led_due.delete();
      mismatches = 0;
    end else begin
      // The result accepted at this edge always stems from an earlier item.
      if (out_valid && !out_stall) begin
        if (led_due.size() == 0) begin
          $error("out_led_on: result item with no level predicted, actual %0b", out_led_on);
          mismatches = mismatches + 1;
        end else begin
          want = led_due.pop_front();
          if (out_led_on !== want) begin
            $error("out_led_on mismatch: expected %0b, actual %0b", want, out_led_on);
            mismatches = mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        led_due.push_back(next_led_level(in_now_ms, in_error_code, in_link_ok, in_armed));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[3:2])
          sled_pkg::RegSafeHalf:
            intervals.safe_half_period_ms  = cfg_pwdata[sled_pkg::IntvW-1:0];
          sled_pkg::RegArmedHalf:
            intervals.armed_half_period_ms = cfg_pwdata[sled_pkg::IntvW-1:0];
          sled_pkg::RegCodePulse:
            intervals.code_pulse_ms        = cfg_pwdata[sled_pkg::IntvW-1:0];
          sled_pkg::RegCodeGap:
            intervals.code_gap_ms          = cfg_pwdata[sled_pkg::IntvW-1:0];
          default: ;
        endcase
      end
    end
    levels_pending = led_due.size();
  end

endmodule

/* test/status_led_blink_code_driver_core_tb.sv */
// Testbench top for the status LED driver: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module status_led_blink_code_driver_core_tb;

  localparam int CycleLimit = 1000000;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic [sled_pkg::TimeW-1:0] in_now_ms;
  logic [sled_pkg::CodeW-1:0] in_error_code;
  logic                       in_link_ok;
  logic                       in_armed;
  logic                       out_valid;
  logic                       out_stall;
  logic                       out_led_on;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [sled_pkg::AddrW-1:0] cfg_paddr;
  logic [sled_pkg::DataW-1:0] cfg_pwdata;
  logic [sled_pkg::DataW-1:0] cfg_prdata;
  logic                       cfg_pready;

  int                         mismatches;
  int                         levels_pending;
  int                         cycle_count = 0;
  logic [sled_pkg::TimeW-1:0] clock_ms;
  bit                         no_idle;

  status_led_blink_code_driver_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_now_ms(in_now_ms), .in_error_code(in_error_code),
    .in_link_ok(in_link_ok), .in_armed(in_armed),
    .out_valid(out_valid), .out_stall(out_stall), .out_led_on(out_led_on),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready)
  );

  status_led_blink_code_driver_core_checker led_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_now_ms(in_now_ms), .in_error_code(in_error_code),
    .in_link_ok(in_link_ok), .in_armed(in_armed),
    .out_valid(out_valid), .out_stall(out_stall), .out_led_on(out_led_on),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_pready(cfg_pready), .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .mismatches(mismatches), .levels_pending(levels_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("status_led_blink_code_driver_core verification failed");
      $finish;
    end
  end

  // Receiver stalls: mostly short bursts, now and then a long one or a free stretch.
  initial begin : result_stalls
    int r;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 10) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 200)) @(negedge clk);
      end else begin
        out_stall <= 1'b1;
        if (r < 85) repeat ($urandom_range(1, 3)) @(negedge clk);
        else repeat ($urandom_range(15, 50)) @(negedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_status(input logic [sled_pkg::TimeW-1:0] now,
                             input logic [sled_pkg::CodeW-1:0] code,
                             input logic link, input logic arm);
    bit took;
    in_valid      <= 1'b1;
    in_now_ms     <= now;
    in_error_code <= code;
    in_link_ok    <= link;
    in_armed      <= arm;
    do begin
      @(posedge clk);
      took = !in_stall;
      @(negedge clk);
    end while (!took);
  endtask

  task automatic rest();
    int r;
    r = $urandom_range(0, 99);
    if (!no_idle && r >= 55) begin
      in_valid <= 1'b0;
      if (r < 90) repeat ($urandom_range(1, 3)) @(negedge clk);
      else repeat ($urandom_range(10, 40)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (levels_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [sled_pkg::IntvW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {{(sled_pkg::DataW-sled_pkg::IntvW){1'b0}}, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_intervals(input logic [sled_pkg::IntvW-1:0] safe_ms,
                               input logic [sled_pkg::IntvW-1:0] armed_ms,
                               input logic [sled_pkg::IntvW-1:0] pulse_ms,
                               input logic [sled_pkg::IntvW-1:0] gap_ms);
    write_reg(sled_pkg::RegSafeHalf, safe_ms);
    write_reg(sled_pkg::RegArmedHalf, armed_ms);
    write_reg(sled_pkg::RegCodePulse, pulse_ms);
    write_reg(sled_pkg::RegCodeGap, gap_ms);
  endtask

  // Time mostly creeps forward around the pulse interval, sometimes jumps or nears the wrap.
  task automatic advance_clock(input int unit, input int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) clock_ms = clock_ms + 32'($urandom_range(0, 2 * unit));
    else if (r < 90) clock_ms = clock_ms + 32'($urandom_range(0, 2 * span));
    else if (r < 97) clock_ms = $urandom();
    else clock_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, 2 * unit));
  endtask

  task automatic run_random(input int count, input int unit, input int span);
    int                         left;
    int                         stretch;
    logic [sled_pkg::CodeW-1:0] code;
    logic [sled_pkg::CodeW-1:0] last_err;
    logic                       link;
    logic                       arm;
    left     = count;
    stretch  = 0;
    code     = '0;
    last_err = 4'd1;
    link     = 1'b1;
    arm      = 1'b0;
    while (left > 0) begin
      if (stretch == 0) begin
        link = 1'($urandom_range(0, 1));
        arm  = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 50) begin
          // Sometimes the last error comes back after a clear without a restart.
          if ($urandom_range(0, 3) == 0) code = last_err;
          else code = 4'($urandom_range(1, 15));
          last_err = code;
          stretch  = $urandom_range(10, 80);
        end else begin
          code    = '0;
          link    = ($urandom_range(0, 99) >= 20);
          stretch = $urandom_range(5, 30);
        end
      end
      advance_clock(unit, span);
      if ($urandom_range(0, 99) < 5)
        send_status(clock_ms, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
      else
        send_status(clock_ms, code, link, arm);
      stretch = stretch - 1;
      left    = left - 1;
      rest();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_now_ms     = '0;
    in_error_code = '0;
    in_link_ok    = 1'b0;
    in_armed      = 1'b0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    clock_ms      = '0;
    no_idle       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk through the modes with the reset intervals.
    send_status(32'd0, 4'd0, 1'b1, 1'b0);  rest();
    send_status(32'd500, 4'd0, 1'b1, 1'b0);  rest();
    send_status(32'd999, 4'd0, 1'b1, 1'b0);  rest();
    send_status(32'd1000, 4'd0, 1'b1, 1'b1);  rest();
    // Lost link lights the LED but keeps the blink phase.
    send_status(32'd1100, 4'd0, 1'b0, 1'b1);  rest();
    send_status(32'd1150, 4'd0, 1'b1, 1'b1);  rest();
    send_status(32'd1200, 4'd1, 1'b1, 1'b0);  rest();
    send_status(32'd1300, 4'd1, 1'b1, 1'b0);  rest();
    send_status(32'd1400, 4'd1, 1'b1, 1'b0);  rest();
    send_status(32'd1500, 4'd1, 1'b1, 1'b0);  rest();
    send_status(32'd2400, 4'd1, 1'b1, 1'b0);  rest();
    send_status(32'd2500, 4'd1, 1'b1, 1'b0);  rest();
    // Clearing the error and bringing the same code back does not restart it.
    send_status(32'd2550, 4'd0, 1'b1, 1'b0);  rest();
    send_status(32'd2600, 4'd1, 1'b1, 1'b0);  rest();
    send_status(32'd2650, 4'd15, 1'b0, 1'b1); rest();
    send_status(32'd2750, 4'd15, 1'b0, 1'b1); rest();
    send_status(32'd2800, 4'd3, 1'b1, 1'b1);  rest();
    send_status(32'hFFFF_FFF0, 4'd0, 1'b1, 1'b1); rest();
    send_status(32'h0000_0010, 4'd0, 1'b1, 1'b1); rest();
    send_status(32'h0000_0060, 4'd0, 1'b1, 1'b1); rest();
    send_status(32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1); rest();
    send_status(32'h0000_0000, 4'd10, 1'b0, 1'b0); rest();
    send_status(32'h5555_5555, 4'd5, 1'b1, 1'b0); rest();
    send_status(32'hAAAA_AAAA, 4'd5, 1'b1, 1'b0); rest();
    clock_ms = 32'hAAAA_AAAA;
    run_random(150, 100, 1000);

    drain();
    set_intervals(16'd7, 16'd2, 16'd3, 16'd10);
    run_random(150, 3, 10);

    drain();
    set_intervals(16'd1, 16'd1, 16'd1, 16'd1);
    no_idle = 1'b1;
    run_random(120, 1, 2);
    drain();
    run_random(30, 1, 2);
    no_idle = 1'b0;

    drain();
    set_intervals(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(150, 65535, 65535);

    // Zero intervals make every timed change fire on each update.
    drain();
    set_intervals(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(100, 5, 5);

    drain();
    set_intervals(16'd300, 16'd40, 16'd25, 16'd180);
    run_random(180, 25, 300);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && levels_pending == 0) begin
      $display("status_led_blink_code_driver_core verification clean");
    end else begin
      $display("status_led_blink_code_driver_core verification failed");
    end
    $finish;
  end

endmodule
